/* rtl/shmr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package shmr_pkg;

    // Field and datapath widths
    localparam int BYTE_W  = 8;
    localparam int HASH_W  = 30;
    localparam int SEED_W  = 64;
    localparam int WIDE_W  = 64;
    localparam int HALF_W  = 32;
    localparam int S_W     = 7;

    // Defaults for the top-level parameters
    localparam int MAX_LAYERS      = 5;
    localparam int LAYERS_DEF      = 5;
    localparam int QUEUE_DEPTH_DEF = 4;

    // Hash arithmetic constants
    localparam logic [HASH_W-1:0] HASH_MOD = HASH_W'(1000000000);
    // h*31 is done as (h << 5) - h
    localparam int HASH_MUL_SHIFT = 5;
    localparam logic [WIDE_W-1:0] ROUND_BASE = WIDE_W'(50);
    localparam logic [WIDE_W-1:0] ROUND_STEP = WIDE_W'(7);

    // Reciprocal reducer: q = ((x >> 29) * MU) >> 35 falls short of x / 1e9
    // by at most two, so the remainder needs at most two subtractions
    localparam int RED_IN_SHIFT = 29;
    localparam int RED_Q_W      = WIDE_W - RED_IN_SHIFT;
    localparam int RED_HI_W     = RED_Q_W - HALF_W;
    localparam logic [WIDE_W-1:0] RED_MU = {WIDE_W{1'b1}} / WIDE_W'(HASH_MOD);

    // 64x64 mod 2^64 product from three 32x32 partial products
    localparam int MUL_STEPS = 3;
    localparam int STEP_W    = $clog2(MUL_STEPS);

    typedef struct packed {
        logic              term;
        logic [BYTE_W-1:0] text_byte;
    } item_t;

    typedef struct packed {
        logic              start;
        logic [WIDE_W-1:0] value;
    } red_req_t;

    typedef struct packed {
        logic              done;
        logic [HASH_W-1:0] rem;
    } red_rsp_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_BYTE_RED,
        BK_MUL,
        BK_ACC,
        BK_MIX_RED,
        BK_EMIT
    } back_state_t;

    // Fibonacci-like sequence with fib(1) = 2, fib(2) = 3 (fib(0) also gives 2); elaboration only
    function automatic logic [WIDE_W-1:0] fib_const(input int unsigned n);
        logic [WIDE_W-1:0] a;
        logic [WIDE_W-1:0] b;
        logic [WIDE_W-1:0] c;
        a = WIDE_W'(1);
        b = WIDE_W'(2);
        for (int unsigned k = 2; k <= n; k++)
        begin
            c = a + b;
            a = b;
            b = c;
        end
        return b;
    endfunction

    function automatic logic [WIDE_W-1:0] round_s(input int unsigned i);
        return ROUND_BASE + ROUND_STEP * WIDE_W'(i);
    endfunction

    function automatic logic [WIDE_W-1:0] round_f1(input int unsigned i);
        return fib_const(int'(round_s(i)) + 1);
    endfunction

    function automatic logic [WIDE_W-1:0] round_f0(input int unsigned i);
        return fib_const(int'(round_s(i)));
    endfunction

    // F0*s mod 2^64, the additive term of y1
    function automatic logic [WIDE_W-1:0] round_k1(input int unsigned i);
        return round_f0(i) * round_s(i);
    endfunction

    // Fm*s mod 2^64, the additive term of y2
    function automatic logic [WIDE_W-1:0] round_k2(input int unsigned i);
        return fib_const(int'(round_s(i)) - 1) * round_s(i);
    endfunction

endpackage

`default_nettype wire

/* rtl/shmr_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface shmr_byte_if import shmr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] text_byte;

    modport source (output valid, output text_byte, input ready);
    modport sink   (input valid, input text_byte, output ready);
endinterface

interface shmr_hash_if import shmr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [HASH_W-1:0] hash_value;

    modport source (output valid, output hash_value, input ready);
    modport sink   (input valid, input hash_value, output ready);
endinterface

interface shmr_seed_if import shmr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [SEED_W-1:0] start_seed;

    modport source (output valid, output start_seed, input ready);
    modport sink   (input valid, input start_seed, output ready);
endinterface

`default_nettype wire

/* rtl/string_hash_with_mixing_rounds.sv */
`timescale 1ns / 1ps
`default_nettype none

// String hash with mixing rounds. Bytes enter on byte_stream, one per beat;
// a zero byte ends the string and produces one hash_value beat on
// hash_stream, other bytes produce nothing. The seed written on seed_write
// starts every string. A front register classifies each byte and pushes it
// into a short queue, so bytes are taken while the back end works. The back
// end takes one queued byte at a time: a nonzero byte makes one request to
// the shared mod 1e9 reducer, and a terminating byte runs LAYERS mixing
// rounds, each product built from three 32x32 partial products and reduced
// by the same reducer, then waits for the result sink. Bytes are held
// back at byte_stream while the queue is full.
module string_hash_with_mixing_rounds import shmr_pkg::*;
#(
    parameter int LAYERS      = LAYERS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    shmr_byte_if.sink   byte_stream,
    shmr_hash_if.source hash_stream,
    shmr_seed_if.sink   seed_write
);

    logic [SEED_W-1:0] seed_reg;
    logic              q_push;
    logic              q_ready;
    logic              q_pop;
    logic              q_empty;
    item_t             q_in_item;
    item_t             q_head;
    red_req_t          red_req;
    red_rsp_t          red_rsp;

    // Take seed writes in any cycle
    assign seed_write.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
        end
        else if (seed_write.valid)
        begin
            seed_reg <= seed_write.start_seed;
        end
    end

    shmr_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_in (byte_stream),
        .q_ready (q_ready),
        .q_push  (q_push),
        .q_item  (q_in_item)
    );

    shmr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (q_in_item),
        .push_ready (q_ready),
        .pop        (q_pop),
        .empty      (q_empty),
        .head_item  (q_head)
    );

    shmr_reduce u_reduce
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (red_req),
        .rsp   (red_rsp)
    );

    shmr_back #(
        .LAYERS (LAYERS)
    ) u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .seed     (seed_reg),
        .q_empty  (q_empty),
        .q_item   (q_head),
        .q_pop    (q_pop),
        .red_req  (red_req),
        .red_rsp  (red_rsp),
        .hash_out (hash_stream)
    );

endmodule

`default_nettype wire

/* rtl/shmr_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module shmr_front import shmr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    shmr_byte_if.sink  byte_in,
    input  logic       q_ready,
    output logic       q_push,
    output item_t      q_item
);

    logic  stage_valid_reg;
    logic  stage_valid_next;
    item_t stage_item_reg;
    logic  take;

    // Accept a beat when the stage is empty or drains this cycle
    assign byte_in.ready = !stage_valid_reg || q_ready;
    assign take          = byte_in.valid && byte_in.ready;
    assign q_push        = stage_valid_reg;
    assign q_item        = stage_item_reg;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (take)
        begin
            stage_valid_next = 1'b1;
        end
        else if (q_ready)
        begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    // Classify: flag the terminating zero byte
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            stage_item_reg.term      <= (byte_in.text_byte == '0);
            stage_item_reg.text_byte <= byte_in.text_byte;
        end
    end

endmodule

`default_nettype wire

/* rtl/shmr_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module shmr_queue import shmr_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  push_ready,
    input  logic  pop,
    output logic  empty,
    output item_t head_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t              entry_reg [DEPTH];
    logic [PTR_W-1:0]   wptr_reg;
    logic [PTR_W-1:0]   wptr_next;
    logic [PTR_W-1:0]   rptr_reg;
    logic [PTR_W-1:0]   rptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign empty      = (count_reg == '0);
    assign head_item  = entry_reg[rptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && !empty;

    // Advance pointers with wrap at the last entry
    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wptr_next = (wptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rptr_next = (rptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // Write the pushed beat into its entry
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

/* rtl/shmr_reduce.sv */
`timescale 1ns / 1ps
`default_nettype none

// 64-bit mod 1e9 by reciprocal multiplication. A request is taken on start;
// done pulses after the valid shift chain, with the remainder held in rem.
module shmr_reduce import shmr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  red_req_t req,
    output red_rsp_t rsp
);

    localparam int STAGES = 5;
    localparam int PX_W   = HALF_W + 2 * RED_HI_W + 1;
    localparam int UP_W   = PX_W + 1;

    localparam logic [HALF_W-1:0]   MU_LO  = RED_MU[HALF_W-1:0];
    localparam logic [RED_HI_W-1:0] MU_HI  = RED_MU[RED_Q_W-1:HALF_W];
    localparam logic [HALF_W-1:0]   MOD_X1 = HALF_W'(HASH_MOD);
    localparam logic [HALF_W-1:0]   MOD_X2 = MOD_X1 << 1;

    logic [STAGES-1:0]   vld_reg;
    logic                done_reg;
    logic [WIDE_W-1:0]   x_reg;
    logic [WIDE_W-1:0]   pll_reg;
    logic [WIDE_W-1:0]   pll_next;
    logic [PX_W-1:0]     px_reg;
    logic [PX_W-1:0]     px_next;
    logic [RED_Q_W-1:0]  q_reg;
    logic [RED_Q_W-1:0]  q_next;
    logic [HALF_W-1:0]   qm_reg;
    logic [HALF_W-1:0]   qm_next;
    logic [HALF_W-1:0]   r_reg;
    logic [HALF_W-1:0]   r_next;
    logic [HASH_W-1:0]   rem_reg;
    logic [HASH_W-1:0]   rem_next;
    logic [RED_Q_W-1:0]  a_top;
    logic [HALF_W-1:0]   a_lo;
    logic [RED_HI_W-1:0] a_hi;
    logic [UP_W-1:0]     upper;

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;

    // Top bits of the dividend times the reciprocal, split into a 32x32 product
    // and small cross terms
    assign a_top    = x_reg[WIDE_W-1:RED_IN_SHIFT];
    assign a_lo     = a_top[HALF_W-1:0];
    assign a_hi     = a_top[RED_Q_W-1:HALF_W];
    assign pll_next = WIDE_W'(a_lo) * WIDE_W'(MU_LO);
    assign px_next  = PX_W'(a_hi) * PX_W'(MU_LO) + PX_W'(a_lo) * PX_W'(MU_HI)
                    + ((PX_W'(a_hi) * PX_W'(MU_HI)) << HALF_W);

    // Combine the partial products and keep the quotient estimate
    assign upper  = UP_W'(px_reg) + UP_W'(pll_reg[WIDE_W-1:HALF_W]);
    assign q_next = upper[RED_Q_W+RED_HI_W-1:RED_HI_W];

    // The remainder is below 3e9, so the low word carries it exactly
    assign qm_next = q_reg[HALF_W-1:0] * MOD_X1;
    assign r_next  = x_reg[HALF_W-1:0] - qm_reg;

    // Subtract the modulus up to twice
    always_comb
    begin
        if (r_reg >= MOD_X2)
        begin
            rem_next = HASH_W'(r_reg - MOD_X2);
        end
        else if (r_reg >= MOD_X1)
        begin
            rem_next = HASH_W'(r_reg - MOD_X1);
        end
        else
        begin
            rem_next = r_reg[HASH_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= {vld_reg[STAGES-2:0], req.start};
            done_reg <= vld_reg[STAGES-1];
        end
    end

    // Advance the data one stage behind its valid bit
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            x_reg <= req.value;
        end
        if (vld_reg[0])
        begin
            pll_reg <= pll_next;
            px_reg  <= px_next;
        end
        if (vld_reg[1])
        begin
            q_reg <= q_next;
        end
        if (vld_reg[2])
        begin
            qm_reg <= qm_next;
        end
        if (vld_reg[3])
        begin
            r_reg <= r_next;
        end
        if (vld_reg[4])
        begin
            rem_reg <= rem_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/shmr_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module shmr_back import shmr_pkg::*;
#(
    parameter int LAYERS = LAYERS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [SEED_W-1:0] seed,
    input  logic              q_empty,
    input  item_t             q_item,
    output logic              q_pop,
    output red_req_t          red_req,
    input  red_rsp_t          red_rsp,
    shmr_hash_if.source       hash_out
);

    localparam int RW = (LAYERS > 1) ? $clog2(LAYERS) : 1;

    // Per-round constant tables
    logic [WIDE_W-1:0] f1_tab [LAYERS];
    logic [WIDE_W-1:0] f0_tab [LAYERS];
    logic [WIDE_W-1:0] k1_tab [LAYERS];
    logic [WIDE_W-1:0] k2_tab [LAYERS];
    logic [S_W-1:0]    s_tab  [LAYERS];

    for (genvar g = 0; g < LAYERS; g++)
    begin : g_round
        localparam logic [WIDE_W-1:0] F1 = round_f1(g);
        localparam logic [WIDE_W-1:0] F0 = round_f0(g);
        localparam logic [WIDE_W-1:0] K1 = round_k1(g);
        localparam logic [WIDE_W-1:0] K2 = round_k2(g);
        localparam logic [WIDE_W-1:0] S  = round_s(g);
        assign f1_tab[g] = F1;
        assign f0_tab[g] = F0;
        assign k1_tab[g] = K1;
        assign k2_tab[g] = K2;
        assign s_tab[g]  = S[S_W-1:0];
    end

    back_state_t       state_reg;
    back_state_t       state_next;
    logic              started_reg;
    logic              started_next;
    logic [HASH_W-1:0] running_reg;
    logic [HASH_W-1:0] running_next;
    logic [RW-1:0]     round_reg;
    logic [RW-1:0]     round_next;
    logic              phase_reg;
    logic              phase_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              hash_valid_reg;
    logic              hash_valid_next;

    logic [WIDE_W-1:0] v_reg;
    logic [WIDE_W-1:0] v_next;
    logic [WIDE_W-1:0] acc_reg;
    logic [WIDE_W-1:0] acc_next;
    logic [WIDE_W-1:0] prod_reg;
    logic [WIDE_W-1:0] prod_next;
    logic [HASH_W-1:0] y1_reg;
    logic [HASH_W-1:0] y1_next;
    logic [HASH_W-1:0] hash_data_reg;
    logic [HASH_W-1:0] hash_data_next;

    logic [WIDE_W-1:0] h_cur;
    logic [WIDE_W-1:0] byte_ext;
    logic [WIDE_W-1:0] byte_sum;
    logic [WIDE_W-1:0] mul_a;
    logic [HALF_W-1:0] a_half;
    logic [HALF_W-1:0] v_half;
    logic [WIDE_W-1:0] acc_add;
    logic [WIDE_W-1:0] acc_sum;
    logic [HASH_W-1:0] mix_out;
    logic [RW-1:0]     round_inc;

    assign hash_out.valid      = hash_valid_reg;
    assign hash_out.hash_value = hash_data_reg;

    // Byte update: h*31 + sext(byte), wrapping at 64 bits
    assign h_cur    = started_reg ? WIDE_W'(running_reg) : seed;
    assign byte_ext = {{(WIDE_W-BYTE_W){q_item.text_byte[BYTE_W-1]}}, q_item.text_byte};
    assign byte_sum = (h_cur << HASH_MUL_SHIFT) - h_cur + byte_ext;

    // Partial product select: lo*lo, hi*lo, lo*hi
    assign mul_a     = phase_reg ? f0_tab[round_reg] : f1_tab[round_reg];
    assign a_half    = (step_reg == STEP_W'(1)) ? mul_a[WIDE_W-1:HALF_W] : mul_a[HALF_W-1:0];
    assign v_half    = (step_reg == STEP_W'(2)) ? v_reg[WIDE_W-1:HALF_W] : v_reg[HALF_W-1:0];
    assign prod_next = WIDE_W'(a_half) * WIDE_W'(v_half);

    assign acc_add   = (step_reg == '0) ? prod_reg : {prod_reg[HALF_W-1:0], {HALF_W{1'b0}}};
    assign acc_sum   = acc_reg + acc_add;
    assign mix_out   = y1_reg ^ red_rsp.rem ^ HASH_W'(s_tab[round_reg]);
    assign round_inc = round_reg + 1'b1;

    always_comb
    begin
        state_next      = state_reg;
        started_next    = started_reg;
        running_next    = running_reg;
        round_next      = round_reg;
        phase_next      = phase_reg;
        step_next       = step_reg;
        hash_valid_next = hash_valid_reg;
        v_next          = v_reg;
        acc_next        = acc_reg;
        y1_next         = y1_reg;
        hash_data_next  = hash_data_reg;
        q_pop           = 1'b0;
        red_req.start   = 1'b0;
        red_req.value   = byte_sum;

        // Drop the result once the sink takes it
        if (hash_valid_reg && hash_out.ready)
        begin
            hash_valid_next = 1'b0;
        end

        case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    if (q_item.term)
                    begin
                        v_next     = h_cur;
                        round_next = '0;
                        phase_next = 1'b0;
                        step_next  = '0;
                        acc_next   = k1_tab[0];
                        state_next = BK_MUL;
                    end
                    else
                    begin
                        red_req.start = 1'b1;
                        state_next    = BK_BYTE_RED;
                    end
                end
            end

            BK_BYTE_RED:
            begin
                if (red_rsp.done)
                begin
                    running_next = red_rsp.rem;
                    started_next = 1'b1;
                    state_next   = BK_IDLE;
                end
            end

            BK_MUL:
            begin
                state_next = BK_ACC;
            end

            // Accumulate one partial product; start the reduction after the last
            BK_ACC:
            begin
                acc_next = acc_sum;
                if (step_reg == STEP_W'(MUL_STEPS - 1))
                begin
                    red_req.start = 1'b1;
                    red_req.value = acc_sum;
                    state_next    = BK_MIX_RED;
                end
                else
                begin
                    step_next  = step_reg + 1'b1;
                    state_next = BK_MUL;
                end
            end

            BK_MIX_RED:
            begin
                if (red_rsp.done)
                begin
                    step_next = '0;
                    if (!phase_reg)
                    begin
                        y1_next    = red_rsp.rem;
                        phase_next = 1'b1;
                        acc_next   = k2_tab[round_reg];
                        state_next = BK_MUL;
                    end
                    else
                    begin
                        v_next     = WIDE_W'(mix_out);
                        phase_next = 1'b0;
                        if (round_reg == RW'(LAYERS - 1))
                        begin
                            state_next = BK_EMIT;
                        end
                        else
                        begin
                            round_next = round_inc;
                            acc_next   = k1_tab[round_inc];
                            state_next = BK_MUL;
                        end
                    end
                end
            end

            // Hold until the output register is free, then restart the string
            BK_EMIT:
            begin
                if (!hash_valid_reg || hash_out.ready)
                begin
                    hash_valid_next = 1'b1;
                    hash_data_next  = v_reg[HASH_W-1:0];
                    started_next    = 1'b0;
                    running_next    = '0;
                    state_next      = BK_IDLE;
                end
            end

            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BK_IDLE;
            started_reg    <= 1'b0;
            running_reg    <= '0;
            round_reg      <= '0;
            phase_reg      <= 1'b0;
            step_reg       <= '0;
            hash_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            started_reg    <= started_next;
            running_reg    <= running_next;
            round_reg      <= round_next;
            phase_reg      <= phase_next;
            step_reg       <= step_next;
            hash_valid_reg <= hash_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg         <= v_next;
        acc_reg       <= acc_next;
        prod_reg      <= prod_next;
        y1_reg        <= y1_next;
        hash_data_reg <= hash_data_next;
    end

endmodule

`default_nettype wire

/* rtl/shmr_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module shmr_checker import shmr_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              hash_valid,
    input logic              hash_ready,
    input logic [HASH_W-1:0] hash_value,
    input logic              seed_valid,
    input logic              seed_ready
);

    // A stalled result beat keeps its valid
    assert property (@(posedge clk) disable iff (!rst_n)
        hash_valid && !hash_ready |=> hash_valid)
        else $error("hash beat dropped while stalled");

    // A stalled result beat keeps its value
    assert property (@(posedge clk) disable iff (!rst_n)
        hash_valid && !hash_ready |=> $stable(hash_value))
        else $error("hash value changed while stalled");

    // Seed writes are never back-pressured
    assert property (@(posedge clk) disable iff (!rst_n)
        seed_valid |-> seed_ready)
        else $error("seed write stalled");

    // Reset, once sampled, must leave no result beat showing
    assert property (@(posedge clk)
        !rst_n |=> !hash_valid)
        else $error("hash beat during reset");

endmodule

bind string_hash_with_mixing_rounds shmr_checker u_shmr_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .hash_valid (hash_stream.valid),
    .hash_ready (hash_stream.ready),
    .hash_value (hash_stream.hash_value),
    .seed_valid (seed_write.valid),
    .seed_ready (seed_write.ready)
);

`default_nettype wire
